// ===== hw/rtl/lmsdfe_pkg.sv =====
// Shared types and constants for the LMS decision-feedback equalizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lmsdfe_pkg;

    // Step registers: unsigned, 24 fraction bits
    localparam int STEP_W    = 16;
    localparam int STEP_FRAC = 24;
    localparam int LEVEL_W   = 4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_STEP = 1'b1;

    localparam logic [STEP_W-1:0] FORWARD_STEP_RESET  = 16'd839;
    localparam logic [STEP_W-1:0] FEEDBACK_STEP_RESET = 16'd0;

    // Per-cycle commands broadcast along a chain
    typedef struct packed {
        logic shift;  // take data from the upstream neighbour
        logic mul;    // register step*error*data
        logic upd;    // apply the LMS correction to the tap
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/lms_decision_feedback_equalizer_top.sv =====
// Top level of the LMS decision-feedback equalizer: control, slicer, LMS error.
// Depends on lmsdfe_pkg and lmsdfe_chain (forward and feedback rows).
//
//  channel | dir | fields (low bit first)
//  s_axis  | in  | new_sample, adapt_enable, training_level
//  m_axis  | out | equalized, decision
//  cfg     | in  | forward_step (index 0), feedback_step (index 1)
//
// The time per item is set by the partial sum walking one cell per cycle along
// the longer row; adapting adds the error, step, multiply and update states.
// Reset is synchronous, active low, and clears taps, window and history.
// A result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module lms_decision_feedback_equalizer_top
    import lmsdfe_pkg::*;
#(
    parameter int FORWARD_TAPS  = 64,
    parameter int FEEDBACK_TAPS = 192,
    parameter int SAMPLE_WIDTH  = 16,
    parameter int TAP_WIDTH     = 24
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // new_sample, adapt_enable, training_level, zero fill
    input  wire [((SAMPLE_WIDTH+5+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // equalized, decision, zero fill
    output logic [((SAMPLE_WIDTH+4+7)/8)*8-1:0] m_axis_tdata,
    input  wire                   i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [STEP_W-1:0]      i_cfg_data
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int TW      = TAP_WIDTH;
    localparam int SF      = SW - 5;
    localparam int TF      = TW - 3;
    localparam int SE_W    = SW + STEP_W + 1;
    localparam int ACC_RAW = TW + SW + $clog2(FORWARD_TAPS + FEEDBACK_TAPS) + 1;
    localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;
    localparam int NMAX    = (FORWARD_TAPS > FEEDBACK_TAPS) ? FORWARD_TAPS : FEEDBACK_TAPS;
    localparam int CNT_W   = $clog2(NMAX);
    localparam int OUT_W   = ((SW+4+7)/8)*8;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (TF-1);
    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);
    localparam logic signed [SW+1:0] E_MAX = (SW+2)'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [SW+1:0] E_MIN = -E_MAX - (SW+2)'(1);
    localparam logic [SW:0] TWO = (SW+1)'(2) << SF;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_EQ, S_ERR, S_SE, S_MUL, S_UPD, S_FIN
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_adapt;
    logic signed [LEVEL_W-1:0] r_level;
    logic [STEP_W-1:0]         r_fstep;
    logic [STEP_W-1:0]         r_bstep;
    logic signed [SW-1:0]      r_y;
    logic signed [LEVEL_W-1:0] r_d;
    logic signed [SW-1:0]      r_e;
    logic signed [SE_W-1:0]    r_fse;
    logic signed [SE_W-1:0]    r_bse;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_data;

    logic                      w_accept;
    logic                      w_out_free;
    t_cell_ctrl                w_fctrl;
    t_cell_ctrl                w_bctrl;
    logic signed [ACC_W-1:0]   w_fsum;
    logic signed [ACC_W-1:0]   w_bsum;
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_sh;
    logic signed [SW-1:0]      n_y;
    logic [SW:0]               w_abs;
    logic [LEVEL_W-1:0]        w_mag;
    logic signed [LEVEL_W-1:0] n_d;
    logic signed [SW+1:0]      w_err;
    logic signed [SW-1:0]      n_e;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Row commands: window shifts on accept, history as the result is registered
    always_comb begin
        w_fctrl.shift = w_accept;
        w_fctrl.mul   = (r_state == S_MUL);
        w_fctrl.upd   = (r_state == S_UPD);
        w_bctrl.shift = (r_state == S_FIN) && w_out_free;
        w_bctrl.mul   = w_fctrl.mul;
        w_bctrl.upd   = w_fctrl.upd;
    end

    lmsdfe_chain #(
        .N          (FORWARD_TAPS),
        .TAP_W      (TW),
        .DATA_W     (SW),
        .SE_W       (SE_W),
        .ACC_W      (ACC_W),
        .PROD_SHIFT (0),
        .UPD_SHIFT  (STEP_FRAC + 2*SF - TF)
    ) u_forward (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_fctrl),
        .i_data  ($signed(s_axis_tdata[SW-1:0])),
        .i_se    (r_fse),
        .o_sum   (w_fsum)
    );

    lmsdfe_chain #(
        .N          (FEEDBACK_TAPS),
        .TAP_W      (TW),
        .DATA_W     (LEVEL_W),
        .SE_W       (SE_W),
        .ACC_W      (ACC_W),
        .PROD_SHIFT (SF),
        .UPD_SHIFT  (STEP_FRAC + SF - TF)
    ) u_feedback (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_bctrl),
        .i_data  (r_d),
        .i_se    (r_bse),
        .o_sum   (w_bsum)
    );

    // Round the combined sum to the sample format and saturate
    always_comb begin
        w_acc = w_fsum - w_bsum;
        w_sh  = (w_acc + ACC_HALF) >>> TF;
        if (w_sh > Y_MAX) begin
            n_y = Y_MAX[SW-1:0];
        end else if (w_sh < Y_MIN) begin
            n_y = Y_MIN[SW-1:0];
        end else begin
            n_y = w_sh[SW-1:0];
        end
    end

    // Slice to the nearest odd level
    always_comb begin
        w_abs = n_y[SW-1] ? -(SW+1)'(n_y) : (SW+1)'(n_y);
        if (w_abs >= 3*TWO) begin
            w_mag = LEVEL_W'(7);
        end else if (w_abs >= 2*TWO) begin
            w_mag = LEVEL_W'(5);
        end else if (w_abs >= TWO) begin
            w_mag = LEVEL_W'(3);
        end else begin
            w_mag = LEVEL_W'(1);
        end
        n_d = n_y[SW-1] ? -$signed(w_mag) : $signed(w_mag);
    end

    // Error against the training level, saturated
    always_comb begin
        w_err = (SW+2)'(r_y) - ((SW+2)'(r_level) <<< SF);
        if (w_err > E_MAX) begin
            n_e = E_MAX[SW-1:0];
        end else if (w_err < E_MIN) begin
            n_e = E_MIN[SW-1:0];
        end else begin
            n_e = w_err[SW-1:0];
        end
    end

    // Sequencer, step registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fstep     <= FORWARD_STEP_RESET;
            r_bstep     <= FEEDBACK_STEP_RESET;
            r_out_valid <= 1'b0;
            r_d         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_FORWARD_STEP:  r_fstep <= i_cfg_data;
                    REG_FEEDBACK_STEP: r_bstep <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_adapt <= s_axis_tdata[SW];
                        r_level <= $signed(s_axis_tdata[SW+LEVEL_W:SW+1]);
                        r_cnt   <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NMAX-1)) begin
                        r_state <= S_EQ;
                    end
                end
                S_EQ: begin
                    r_y     <= n_y;
                    r_d     <= n_d;
                    r_state <= r_adapt ? S_ERR : S_FIN;
                end
                S_ERR: begin
                    r_e     <= n_e;
                    r_state <= S_SE;
                end
                S_SE: begin
                    r_fse   <= SE_W'($signed({1'b0, r_fstep}) * r_e);
                    r_bse   <= SE_W'($signed({1'b0, r_bstep}) * r_e);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= OUT_W'({r_d, r_y});
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/lmsdfe_cell.sv =====
// One equalizer cell: a tap, its data word and a slice of the running sum.
// Depends on lmsdfe_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module lmsdfe_cell
    import lmsdfe_pkg::*;
#(
    parameter int TAP_W      = 24,
    parameter int DATA_W     = 16,
    parameter int SE_W       = 33,
    parameter int ACC_W      = 48,
    parameter int PROD_SHIFT = 0,
    parameter int UPD_SHIFT  = 25
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire signed [DATA_W-1:0]  i_data,
    output logic signed [DATA_W-1:0] o_data,
    input  wire signed [SE_W-1:0]    i_se,
    input  wire signed [ACC_W-1:0]   i_psum,
    output logic signed [ACC_W-1:0]  o_psum
);

    localparam int P_W  = SE_W + DATA_W;
    localparam int RS_H = (UPD_SHIFT > 0) ? UPD_SHIFT - 1 : 0;
    localparam logic signed [P_W:0] HALF =
        (UPD_SHIFT > 0) ? ((P_W+1)'(1) <<< RS_H) : '0;
    localparam logic signed [P_W+1:0] TAP_MAX = (P_W+2)'({1'b0, {(TAP_W-1){1'b1}}});
    localparam logic signed [P_W+1:0] TAP_MIN = -TAP_MAX - (P_W+2)'(1);

    logic signed [TAP_W-1:0]        r_tap;
    logic signed [DATA_W-1:0]       r_data;
    logic signed [ACC_W-1:0]        r_psum;
    logic signed [P_W-1:0]          r_prod;
    logic signed [TAP_W+DATA_W-1:0] w_mac;
    logic signed [ACC_W-1:0]        w_mac_ext;
    logic signed [P_W:0]            w_rnd;
    logic signed [P_W+1:0]          w_diff;
    logic signed [TAP_W-1:0]        n_tap;

    // Product into the sum, aligned to the accumulator
    always_comb begin
        w_mac     = r_tap * r_data;
        w_mac_ext = ACC_W'(w_mac) <<< PROD_SHIFT;
    end

    // Round the correction half up, subtract and saturate
    always_comb begin
        w_rnd  = ((P_W+1)'(r_prod) + HALF) >>> UPD_SHIFT;
        w_diff = (P_W+2)'(r_tap) - (P_W+2)'(w_rnd);
        if (w_diff > TAP_MAX) begin
            n_tap = TAP_MAX[TAP_W-1:0];
        end else if (w_diff < TAP_MIN) begin
            n_tap = TAP_MIN[TAP_W-1:0];
        end else begin
            n_tap = w_diff[TAP_W-1:0];
        end
    end

    // Hold tap and data; shift and adapt on command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap  <= '0;
            r_data <= '0;
        end else begin
            if (i_ctrl.shift) begin
                r_data <= i_data;
            end
            if (i_ctrl.upd) begin
                r_tap <= n_tap;
            end
        end
    end

    // Hand the partial sum on and keep the correction product
    always_ff @(posedge i_clk) begin
        r_psum <= i_psum + w_mac_ext;
        if (i_ctrl.mul) begin
            r_prod <= i_se * r_data;
        end
    end

    assign o_data = r_data;
    assign o_psum = r_psum;

endmodule

`default_nettype wire

// ===== hw/rtl/lmsdfe_chain.sv =====
// Row of equalizer cells sharing one data shift line and one sum chain.
// Depends on lmsdfe_pkg and lmsdfe_cell.
`timescale 1ns / 1ps
`default_nettype none

module lmsdfe_chain
    import lmsdfe_pkg::*;
#(
    parameter int N          = 64,
    parameter int TAP_W      = 24,
    parameter int DATA_W     = 16,
    parameter int SE_W       = 33,
    parameter int ACC_W      = 48,
    parameter int PROD_SHIFT = 0,
    parameter int UPD_SHIFT  = 25
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire signed [DATA_W-1:0]  i_data,
    input  wire signed [SE_W-1:0]    i_se,
    output logic signed [ACC_W-1:0]  o_sum
);

    logic signed [DATA_W-1:0] w_data [N];
    logic signed [ACC_W-1:0]  w_psum [N];

    // Newest word enters at the top cell, sum runs from cell 0 upward
    for (genvar k = 0; k < N; k++) begin : g_cell
        logic signed [DATA_W-1:0] w_din;
        logic signed [ACC_W-1:0]  w_pin;
        if (k == N-1) begin : g_top
            assign w_din = i_data;
        end else begin : g_mid
            assign w_din = w_data[k+1];
        end
        if (k == 0) begin : g_first
            assign w_pin = '0;
        end else begin : g_rest
            assign w_pin = w_psum[k-1];
        end
        lmsdfe_cell #(
            .TAP_W      (TAP_W),
            .DATA_W     (DATA_W),
            .SE_W       (SE_W),
            .ACC_W      (ACC_W),
            .PROD_SHIFT (PROD_SHIFT),
            .UPD_SHIFT  (UPD_SHIFT)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_data  (w_din),
            .o_data  (w_data[k]),
            .i_se    (i_se),
            .i_psum  (w_pin),
            .o_psum  (w_psum[k])
        );
    end

    assign o_sum = w_psum[N-1];

endmodule

`default_nettype wire

// ===== sim/lmsdfe_checker.sv =====
// Scoreboard for the LMS decision-feedback equalizer: watches the item and config
// channels, predicts each result in fixed point and compares it. Needs lmsdfe_pkg.
`timescale 1ns / 1ps

module lmsdfe_checker
    import lmsdfe_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    // new_sample, adapt_enable, training_level, zero fill
    input  wire [23:0]          i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    // equalized, decision, zero fill
    input  wire [23:0]          i_out_data,
    input  wire                 i_cfg_wr_en,
    input  wire [CFG_IDX_W-1:0] i_cfg_index,
    input  wire [STEP_W-1:0]    i_cfg_data,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_results
);

    localparam int NFWD = 64;
    localparam int NFBK = 192;
    localparam int SFRAC = 11;
    localparam int TFRAC = 21;

    // decision sits in the upper bits, equalized in the lower
    typedef struct packed {
        logic signed [3:0]  decision;
        logic signed [15:0] equalized;
    } eq_result_t;

    eq_result_t expected_q[$];

    longint window[NFWD];
    longint fwd_tap[NFWD];
    longint fbk_tap[NFBK];
    longint past_dec[NFBK];
    int     ring_ptr;
    longint fwd_step;
    longint fbk_step;

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // round half up, then floor
    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint slice(longint y);
        longint a;
        longint d;
        a = (y < 0) ? -y : y;
        if (a >= 6 * 2048) d = 7;
        else if (a >= 4 * 2048) d = 5;
        else if (a >= 2 * 2048) d = 3;
        else d = 1;
        return (y < 0) ? -d : d;
    endfunction

    // Advance the equaliser state by one item and queue its result
    task automatic equalize(input logic [23:0] data);
        longint acc, y, d, e, p;
        longint smp, lvl;
        int k;
        eq_result_t r;
        smp = longint'($signed(data[15:0]));
        lvl = longint'($signed(data[20:17]));
        for (int i = 0; i < NFWD - 1; i++) window[i] = window[i + 1];
        window[NFWD - 1] = smp;
        acc = 0;
        for (int i = 0; i < NFWD; i++) acc += fwd_tap[i] * window[i];
        ring_ptr = (ring_ptr + 1) % NFBK;
        for (int i = 0; i < NFBK; i++) begin
            k = (ring_ptr + i) % NFBK;
            acc -= fbk_tap[i] * (past_dec[k] <<< SFRAC);
        end
        y = clamp(rnd_shift(acc, TFRAC), 16);
        d = slice(y);
        if (data[16]) begin
            e = clamp(y - (lvl <<< SFRAC), 16);
            for (int i = 0; i < NFWD; i++) begin
                p = fwd_step * e * window[i];
                fwd_tap[i] = clamp(fwd_tap[i] - rnd_shift(p, STEP_FRAC + 2 * SFRAC - TFRAC), 24);
            end
            for (int i = 0; i < NFBK; i++) begin
                k = (ring_ptr + i) % NFBK;
                p = fbk_step * e * past_dec[k];
                fbk_tap[i] = clamp(fbk_tap[i] - rnd_shift(p, STEP_FRAC + SFRAC - TFRAC), 24);
            end
        end
        past_dec[ring_ptr] = d;
        r.equalized = y[15:0];
        r.decision = d[3:0];
        expected_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        eq_result_t want;
        eq_result_t got;
        if (!i_rst_n) begin
            for (int i = 0; i < NFWD; i++) begin
                window[i] = 0;
                fwd_tap[i] = 0;
            end
            for (int i = 0; i < NFBK; i++) begin
                fbk_tap[i] = 0;
                past_dec[i] = 0;
            end
            ring_ptr = 0;
            fwd_step = FORWARD_STEP_RESET;
            fbk_step = FEEDBACK_STEP_RESET;
            expected_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_FORWARD_STEP) fwd_step = i_cfg_data;
                else if (i_cfg_index == REG_FEEDBACK_STEP) fbk_step = i_cfg_data;
            end
            // compare the outgoing item before predicting the incoming one
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[19:0];
                o_results = o_results + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result equalized=%0d decision=%0d", $time,
                             got.equalized, got.decision);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.equalized !== want.equalized) begin
                        $display("%0t: equalized expected %0d actual %0d", $time,
                                 want.equalized, got.equalized);
                        o_errors = o_errors + 1;
                    end
                    if (got.decision !== want.decision) begin
                        $display("%0t: decision expected %0d actual %0d", $time,
                                 want.decision, got.decision);
                        o_errors = o_errors + 1;
                    end
                    if (i_out_data[23:20] !== 4'd0) begin
                        $display("%0t: fill bits expected 0 actual %h", $time,
                                 i_out_data[23:20]);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) equalize(i_in_data);
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== sim/tb.sv =====
// Stimulus and verdict for the LMS decision-feedback equalizer top level.
// Needs lmsdfe_pkg, lms_decision_feedback_equalizer_top and lmsdfe_checker.
`timescale 1ns / 1ps

module tb;
    import lmsdfe_pkg::*;

    localparam int WATCHDOG = 5000;
    localparam int DRAIN = 250;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_FORWARD_STEP;
    logic [STEP_W-1:0]    i_cfg_data = '0;

    int  errors, pending, results;
    bit  calm = 1'b0;
    int  sent = 0;
    int  quiet = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    lms_decision_feedback_equalizer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    lmsdfe_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Receiver: stall in random bursts, never in the calm tail
    always @(negedge i_clk) begin
        int burst;
        if (!i_rst_n || calm || $urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1'b1;
        end else begin
            burst = $urandom_range(1, 7);
            m_axis_tready <= 1'b0;
            repeat (burst - 1) @(negedge i_clk);
        end
    end

    // Watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else if (i_rst_n)
            quiet = quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("FAIL lms_decision_feedback_equalizer_top");
            $finish;
        end
    end

    task automatic send_item(input logic signed [15:0] smp, input bit adp,
                             input logic [3:0] lvl);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, lvl, adp, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Hold until every result is back and the pipeline has emptied
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    // Mostly clean symbols with noise, the rest arbitrary samples
    task automatic random_item();
        logic [3:0] lvl;
        int noisy;
        if ($urandom_range(0, 9) < 8) lvl = 4'(2 * $urandom_range(0, 7) - 7);
        else lvl = 4'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            noisy = int'($signed(lvl)) * 2048 + $urandom_range(0, 1400) - 700;
            send_item(16'(noisy), $urandom_range(0, 9) < 8, lvl);
        end else begin
            send_item(16'($urandom), $urandom_range(0, 1), lvl);
        end
    endtask

    logic [STEP_W-1:0] fwd_set[5] = '{16'd0, 16'd65535, 16'd2000, 16'd1, 16'd839};
    logic [STEP_W-1:0] fbk_set[5] = '{16'd65535, 16'd0, 16'd300, 16'd40000, 16'd0};

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: sample extremes, every training level, both modes
        send_item(16'sh7fff, 1'b0, 4'sd7);
        send_item(16'sh8000, 1'b0, -4'sd7);
        send_item(16'sd0, 1'b1, 4'sd0);
        send_item(16'sh7fff, 1'b1, 4'sd7);
        send_item(16'sh8000, 1'b1, -4'sd8);
        send_item(-16'sd4096, 1'b1, -4'sd3);
        send_item(16'sd4096, 1'b1, 4'sd3);
        send_item(16'sd12288, 1'b1, 4'sd7);
        send_item(-16'sd8192, 1'b1, -4'sd5);
        for (int l = -8; l <= 7; l++) send_item(16'(l * 2048), 1'b1, 4'(l));

        // Random phases, each under its own step settings
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            write_reg(REG_FORWARD_STEP, fwd_set[ph]);
            write_reg(REG_FEEDBACK_STEP, fbk_set[ph]);
            if (ph == 4) calm = 1'b1;
            for (int n = 0; n < 95; n++) random_item();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        $display("Sent %0d items over 6 step settings, %0d results checked, %0d mismatches.",
                 sent, results, errors);
        if (errors == 0 && pending == 0) begin
            $display("PASS lms_decision_feedback_equalizer_top");
        end else begin
            $display("FAIL lms_decision_feedback_equalizer_top");
        end
        $finish;
    end

endmodule
